[design/edd_pkg.sv]
// Shared types, widths and arithmetic helpers for the error diffusion dither.
// No dependencies.

package edd_pkg;

  localparam int unsigned PIX_W           = 8;
  localparam int unsigned CFG_W           = 11;
  localparam int unsigned ERR_W           = 11;
  localparam int unsigned SUM_W           = 13;
  localparam int unsigned PROD_W          = 16;
  localparam int unsigned DEF_MAX_WIDTH   = 1024;
  localparam int unsigned DEF_LINE_WIDTH  = 1024;
  localparam int unsigned MIN_LINE_WIDTH  = 3;

  typedef enum logic [1:0] {
    KIND_FIRST,
    KIND_MID,
    KIND_LAST
  } kind_e;

  // signed divide by 16, truncating toward zero
  function automatic logic signed [PROD_W-1:0] div16_tz(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] b;
    b = v[PROD_W-1] ? (v + 16'sd15) : v;
    return b >>> 4;
  endfunction

  function automatic logic signed [ERR_W-1:0] sat_err(input logic signed [PROD_W-1:0] v);
    logic signed [ERR_W-1:0] r;
    if (v > 16'sd1023) begin
      r = 11'sd1023;
    end else if (v < -16'sd1024) begin
      r = 11'h400;
    end else begin
      r = v[ERR_W-1:0];
    end
    return r;
  endfunction

endpackage

[design/edd_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.

module edd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/error_diffusion_dither_core.sv]
// Error diffusion dither core: one pixel out per pixel in; interior binarized.
// Depends on edd_pkg and edd_ram (line store of errors for the next row).
//
//  channel | signals                                   | transfer
//  --------+-------------------------------------------+-----------------------
//  input   | in_valid_i, in_ready_o, gray_i,           | valid & ready
//          | frame_start_i                             |
//  output  | out_valid_o, out_ready_i, pixel_out_o,    | valid & ready
//          | line_end_o                                |
//  config  | cfg_we_i, cfg_wdata_i (line_width)        | write on we, no wait
//
// One pixel per cycle sustained while the output is not stalled; an accepted
// input passes the stage register (error store read), then is diffused into
// the output register, where output valid rises.
// After reset all MAX_WIDTH entries of the error store are cleared, with in_ready_o low.
// A stalled output holds the pipe; the input stays ready while the output
// register drains in the same cycle.

module error_diffusion_dither_core #(
  parameter int unsigned MAX_WIDTH = edd_pkg::DEF_MAX_WIDTH
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [edd_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [edd_pkg::PIX_W-1:0] gray_i,
  input  logic                      frame_start_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [edd_pkg::PIX_W-1:0] pixel_out_o,
  output logic                      line_end_o
);

  import edd_pkg::*;

  localparam int unsigned AW      = $clog2(MAX_WIDTH);
  localparam int unsigned WW      = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;
  localparam int unsigned LAST_RST =
    ((DEF_LINE_WIDTH > MAX_WIDTH) ? MAX_WIDTH : DEF_LINE_WIDTH) - 1;

  // configuration: stored as the clamped last column index
  logic [AW-1:0] last_q, last_d;
  logic [WW-1:0] cfg_ext, eff_w;

  always_comb begin
    cfg_ext = WW'(cfg_wdata_i);
    if (cfg_ext < WW'(MIN_LINE_WIDTH)) begin
      eff_w = WW'(MIN_LINE_WIDTH);
    end else if (cfg_ext > WW'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = cfg_ext;
    end
    last_d = cfg_we_i ? AW'(eff_w - WW'(1)) : last_q;
  end

  // clearing pass
  logic          clr_active_q, clr_active_d;
  logic [AW-1:0] clr_addr_q, clr_addr_d;

  // stage 0 / column tracking
  logic          in_acc;
  logic [AW-1:0] column_q, column_d;
  logic          first_line_q, first_line_d;
  logic [AW-1:0] x_raw, x0;
  logic          fl0;
  kind_e         kind0;

  // stage 1
  logic             s1_valid_q, s1_valid_d;
  logic             s1_adv;
  logic [PIX_W-1:0] s1_gray_q;
  logic [AW-1:0]    s1_x_q;
  kind_e            s1_kind_q;
  logic             s1_fl_q;

  // diffusion state
  logic signed [ERR_W-1:0] rc_q, rc_d;
  logic signed [ERR_W-1:0] pbl_q, pbl_d;
  logic signed [ERR_W-1:0] pb_q, pb_d;

  // output register
  logic             out_valid_q, out_valid_d;
  logic [PIX_W-1:0] pix_q, pix_d;
  logic             lend_q, lend_d;

  // RAM
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [ERR_W-1:0] ram_wdata, ram_rdata;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !clr_active_q && (!s1_valid_q || s1_adv);
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    x_raw = frame_start_i ? '0 : column_q;
    x0    = (x_raw > last_q) ? last_q : x_raw;
    fl0   = frame_start_i || first_line_q;
    if (x0 == '0) begin
      kind0 = KIND_FIRST;
    end else if (x0 == last_q) begin
      kind0 = KIND_LAST;
    end else begin
      kind0 = KIND_MID;
    end

    column_d     = column_q;
    first_line_d = first_line_q;
    if (in_acc) begin
      unique case (kind0)
        KIND_FIRST: begin
          column_d     = AW'(1);
          first_line_d = fl0;
        end
        KIND_LAST: begin
          column_d     = '0;
          first_line_d = 1'b0;
        end
        default: begin
          column_d     = x0 + AW'(1);
          first_line_d = fl0;
        end
      endcase
    end
  end

  assign ram_re    = in_acc && (kind0 == KIND_MID);
  assign ram_raddr = x0;

  // diffusion datapath
  logic signed [ERR_W-1:0]  above;
  logic signed [SUM_W-1:0]  sum, err;
  logic                     hi;
  logic signed [PROD_W-1:0] err16, e7, e3, e5, e1;
  logic signed [PROD_W-1:0] pbl16, pb16;
  logic signed [ERR_W-1:0]  below_wr;

  always_comb begin
    above = s1_fl_q ? '0 : ram_rdata;
    sum   = {{(SUM_W-ERR_W){above[ERR_W-1]}}, above}
          + {{(SUM_W-ERR_W){rc_q[ERR_W-1]}}, rc_q}
          + {{(SUM_W-PIX_W){1'b0}}, s1_gray_q};
    hi    = (sum >= 13'sd128);
    err   = hi ? (sum - 13'sd255) : sum;
    err16 = {{(PROD_W-SUM_W){err[SUM_W-1]}}, err};
    e7    = div16_tz(err16 * 16'sd7);
    e3    = div16_tz(err16 * 16'sd3);
    e5    = div16_tz(err16 * 16'sd5);
    e1    = div16_tz(err16);
    pbl16 = {{(PROD_W-ERR_W){pbl_q[ERR_W-1]}}, pbl_q};
    pb16  = {{(PROD_W-ERR_W){pb_q[ERR_W-1]}}, pb_q};
    below_wr = sat_err(pbl16 + e3);
  end

  always_comb begin
    rc_d      = rc_q;
    pbl_d     = pbl_q;
    pb_d      = pb_q;
    pix_d     = pix_q;
    lend_d    = lend_q;
    ram_we    = 1'b0;
    ram_waddr = s1_x_q - AW'(1);
    ram_wdata = '0;
    if (clr_active_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
    end else if (s1_adv) begin
      ram_we = 1'b1;
      unique case (s1_kind_q)
        KIND_FIRST: begin
          rc_d      = '0;
          pbl_d     = '0;
          pb_d      = '0;
          ram_waddr = '0;
          pix_d     = s1_gray_q;
          lend_d    = 1'b0;
        end
        KIND_LAST: begin
          ram_wdata = pbl_q;
          rc_d      = '0;
          pbl_d     = '0;
          pb_d      = '0;
          pix_d     = s1_gray_q;
          lend_d    = 1'b1;
        end
        default: begin
          ram_wdata = below_wr;
          rc_d      = sat_err(e7);
          pbl_d     = sat_err(pb16 + e5);
          pb_d      = sat_err(e1);
          pix_d     = hi ? 8'd255 : 8'd0;
          lend_d    = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    clr_active_d = clr_active_q;
    clr_addr_d   = clr_addr_q;
    if (clr_active_q) begin
      clr_addr_d = clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(MAX_WIDTH - 1)) begin
        clr_active_d = 1'b0;
      end
    end
    s1_valid_d = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);
    out_valid_d = s1_adv ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q       <= AW'(LAST_RST);
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
      column_q     <= '0;
      first_line_q <= 1'b1;
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      rc_q         <= '0;
      pbl_q        <= '0;
      pb_q         <= '0;
    end else begin
      last_q       <= last_d;
      clr_active_q <= clr_active_d;
      clr_addr_q   <= clr_addr_d;
      column_q     <= column_d;
      first_line_q <= first_line_d;
      s1_valid_q   <= s1_valid_d;
      out_valid_q  <= out_valid_d;
      rc_q         <= rc_d;
      pbl_q        <= pbl_d;
      pb_q         <= pb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_gray_q <= gray_i;
      s1_x_q    <= x0;
      s1_kind_q <= kind0;
      s1_fl_q   <= fl0;
    end
    pix_q  <= pix_d;
    lend_q <= lend_d;
  end

  edd_ram #(
    .WIDTH (ERR_W),
    .DEPTH (MAX_WIDTH)
  ) u_err_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = pix_q;
  assign line_end_o  = lend_q;

  a_no_rw_same_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re && ram_we |-> ram_raddr != ram_waddr)
    else $error("error store read and write collide");

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_active_q |-> !in_acc)
    else $error("transaction accepted during error store clear");

  a_mid_binary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_kind_q == KIND_MID |=> pixel_out_o == 8'd0 || pixel_out_o == 8'd255)
    else $error("interior pixel not binarized");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_kind_q == KIND_LAST |=> rc_q == '0 && pbl_q == '0 && pb_q == '0 && line_end_o)
    else $error("line end left error carries set");

endmodule
